// ----- sv/bske_pkg.sv -----
// Shared constants and types for the blue-screen key with 7x7 mask erosion.
// Used by bske_cell, bske_window and blue_screen_key_erode_mask; no dependencies.
package bske_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int DELAY_DEPTH = 4096;

  localparam int WIN_SIZE = 7;
  localparam int WIN_RAD  = 3;
  localparam int MIN_SIZE = 7;
  localparam int HIST_W   = WIN_SIZE - 1;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WU_W   = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W = $clog2(DELAY_DEPTH);
  localparam int FW_W   = 11;
  localparam int FH_W   = 12;
  localparam int ROW_W  = FH_W + 1;
  localparam int OFS_W  = $clog2(WIN_SIZE);
  localparam int PIX_W  = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_MODE     = 3'd0,
    CFG_FRAME_WIDTH  = 3'd1,
    CFG_FRAME_HEIGHT = 3'd2,
    CFG_KEY_MARGIN   = 3'd3
  } cfg_reg_t;

  // Control handed to the erosion window once per request leaving the first stage.
  typedef struct packed {
    logic             shift;
    logic             vbit;
    logic [COL_W-1:0] out_col;
    logic [WU_W-1:0]  width;
  } win_ctl_t;

endpackage

// ----- sv/bske_cell.sv -----
// One column cell of the horizontal erosion window.
// Depends on bske_pkg for widths.
module bske_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic                       bit_in,
  input  logic [bske_pkg::OFS_W-1:0] cell_ofs,
  input  logic [bske_pkg::COL_W-1:0] out_col,
  input  logic [bske_pkg::WU_W-1:0]  width,
  input  logic                       and_in,
  output logic                       bit_out,
  output logic                       and_out
);

  localparam int CMP_W = bske_pkg::WU_W + 1;

  logic          bit_r;
  logic          bit_nxt;
  logic [CMP_W-1:0] col_plus;
  logic [CMP_W-1:0] ofs_ext;
  logic          in_range;

  assign bit_nxt = shift_en ? bit_in : bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b1;
    end else begin
      bit_r <= bit_nxt;
    end
  end

  // The cell holds the column out_col + WIN_RAD - cell_ofs; columns off the
  // row edges count as foreground.
  assign col_plus = CMP_W'(out_col) + CMP_W'(bske_pkg::WIN_RAD);
  assign ofs_ext  = CMP_W'(cell_ofs);
  assign in_range = (col_plus >= ofs_ext) && (col_plus < (CMP_W'(width) + ofs_ext));

  assign bit_out = bit_r;
  assign and_out = and_in & (bit_r | ~in_range);

endmodule

// ----- sv/bske_window.sv -----
// Row of seven column cells forming the horizontal part of the 7x7 erosion.
// Depends on bske_pkg and bske_cell.
module bske_window (
  input  logic               clk,
  input  logic               rst_n,
  input  bske_pkg::win_ctl_t ctl,
  output logic               eroded
);

  logic [bske_pkg::WIN_SIZE-1:0] bits;
  logic [bske_pkg::WIN_SIZE:0]   ands;

  assign ands[0] = 1'b1;

  for (genvar k = 0; k < bske_pkg::WIN_SIZE; k++) begin : g_cell
    logic shift_src;
    if (k == 0) begin : g_head
      assign shift_src = ctl.vbit;
    end else begin : g_body
      assign shift_src = bits[k-1];
    end
    bske_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (ctl.shift),
      .bit_in   (shift_src),
      .cell_ofs (bske_pkg::OFS_W'(k)),
      .out_col  (ctl.out_col),
      .width    (ctl.width),
      .and_in   (ands[k]),
      .bit_out  (bits[k]),
      .and_out  (ands[k+1])
    );
  end

  assign eroded = ands[bske_pkg::WIN_SIZE];

endmodule

// ----- sv/blue_screen_key_erode_mask.sv -----
// Top level: blue-screen chroma key, 7x7 mask erosion and pixel delay line.
// Depends on bske_pkg and bske_window.
//
// Pixels enter in raster order on the in_ channel, one per cycle while in_ready is high.
// A real pixel has in_mode 0; a padding request (in_mode 1) stands for a black
// pixel inside the frame and, after the last pixel, flushes one delayed output.
// Each pixel comes out 3 rows plus 3 pixels of requests later, with all
// channels cleared when its eroded mask bit is 0; out_last_of_frame marks the
// final pixel, after which a new frame starts.
// Pipeline: input stage with registered line-buffer and delay-line reads, a
// vertical-mask stage feeding the cell row, and the output register. A request
// passes stage 1, stage 2 and the output register after it is accepted. The
// block sustains 1 request per cycle while out_ready stays high; the column
// history read and write-back touch different columns on adjacent requests.
// When out_ready is low the pipeline still takes up to two more requests
// before in_ready drops; nothing is lost or repeated.
// Reset clears the counters and pipeline valid bits and loads the register
// defaults (pass-through, 640 x 480, margin 5); no clearing pass is needed.
// Config writes via cfg_ are always ready; width or height writes restart the frame.
module blue_screen_key_erode_mask (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [bske_pkg::PIX_W-1:0]      in_blue_in,
  input  logic [bske_pkg::PIX_W-1:0]      in_green_in,
  input  logic [bske_pkg::PIX_W-1:0]      in_red_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bske_pkg::PIX_W-1:0]      out_blue_out,
  output logic [bske_pkg::PIX_W-1:0]      out_green_out,
  output logic [bske_pkg::PIX_W-1:0]      out_red_out,
  output logic                            out_foreground,
  output logic                            out_last_of_frame,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bske_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bske_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int PIX3_W = 3 * bske_pkg::PIX_W;
  localparam int COL_W  = bske_pkg::COL_W;
  localparam int ROW_W  = bske_pkg::ROW_W;
  localparam int WU_W   = bske_pkg::WU_W;
  localparam int ADDR_W = bske_pkg::ADDR_W;
  localparam int HIST_W = bske_pkg::HIST_W;
  localparam int WIN    = bske_pkg::WIN_SIZE;
  localparam int RAD    = bske_pkg::WIN_RAD;
  localparam int PW     = bske_pkg::PIX_W;

  // Configuration registers.
  logic                      key_mode_r;
  logic [bske_pkg::FW_W-1:0] frame_width_r;
  logic [bske_pkg::FH_W-1:0] frame_height_r;
  logic [PW-1:0]             key_margin_r;
  logic                      size_write;

  // Input position.
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;

  logic [WU_W-1:0]          w_use;
  logic [bske_pkg::FH_W-1:0] h_use;
  logic [ADDR_W-1:0]        lag;
  logic                     accept;

  // Input stage logic.
  logic [PW-1:0]     pb, pg, pr, gmax, lim;
  logic              key0, in_frame, has_out0, last0;
  logic [WIN-1:0]    rowok0;
  logic [COL_W-1:0]  ocol0;
  logic [WU_W-1:0]   col_inc;

  // Memories.
  logic [HIST_W-1:0] key_hist_mem [bske_pkg::MAX_WIDTH];
  logic [PIX3_W-1:0] pix_delay_mem [bske_pkg::DELAY_DEPTH];

  // Stage 1.
  logic              s1_valid_r;
  logic              s1_key_r, s1_has_out_r, s1_last_r;
  logic [WIN-1:0]    s1_rowok_r;
  logic [COL_W-1:0]  s1_col_r, s1_ocol_r;
  logic [HIST_W-1:0] s1_hist_r;
  logic [PIX3_W-1:0] s1_pix_r;
  logic              s1_adv, s1_move;
  logic [WIN-1:0]    vcol;
  logic              vbit;
  logic [HIST_W-1:0] hist_wr;

  // Stage 2.
  logic              s2_valid_r;
  logic              s2_has_out_r, s2_last_r;
  logic [COL_W-1:0]  s2_ocol_r;
  logic [PIX3_W-1:0] s2_pix_r;
  logic              s2_adv, s2_move;
  logic              eroded;
  bske_pkg::win_ctl_t win_ctl;

  // Output register.
  logic              out_valid_r;
  logic [PIX3_W-1:0] out_pix_r;
  logic              out_fg_r, out_last_r;

  // ---------------------------------------------------------------- config
  assign cfg_ready  = 1'b1;
  assign size_write = cfg_valid &&
                      ((cfg_index == bske_pkg::CFG_FRAME_WIDTH) ||
                       (cfg_index == bske_pkg::CFG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r     <= 1'b0;
      frame_width_r  <= bske_pkg::FW_W'(640);
      frame_height_r <= bske_pkg::FH_W'(480);
      key_margin_r   <= PW'(5);
    end else if (cfg_valid) begin
      case (cfg_index)
        bske_pkg::CFG_KEY_MODE:     key_mode_r     <= cfg_data[0];
        bske_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[bske_pkg::FW_W-1:0];
        bske_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[bske_pkg::FH_W-1:0];
        bske_pkg::CFG_KEY_MARGIN:   key_margin_r   <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(frame_width_r) > bske_pkg::MAX_WIDTH) begin
      w_use = WU_W'(bske_pkg::MAX_WIDTH);
    end else if (int'(frame_width_r) < bske_pkg::MIN_SIZE) begin
      w_use = WU_W'(bske_pkg::MIN_SIZE);
    end else begin
      w_use = WU_W'(frame_width_r);
    end
    if (int'(frame_height_r) < bske_pkg::MIN_SIZE) begin
      h_use = bske_pkg::FH_W'(bske_pkg::MIN_SIZE);
    end else begin
      h_use = frame_height_r;
    end
  end

  assign lag = ADDR_W'(RAD * int'(w_use) + RAD);

  // ----------------------------------------------------------- input stage
  assign accept   = in_valid && in_ready;
  assign pb       = in_mode ? '0 : in_blue_in;
  assign pg       = in_mode ? '0 : in_green_in;
  assign pr       = in_mode ? '0 : in_red_in;
  assign gmax     = (pg > pr) ? pg : pr;
  assign lim      = (gmax > key_margin_r) ? (gmax - key_margin_r) : '0;
  assign key0     = !key_mode_r || (pb < lim);
  assign in_frame = in_row_r < ROW_W'(h_use);

  // Bit j of a column vector is row in_row_r - j; rows outside the frame
  // count as foreground.
  always_comb begin
    for (int j = 0; j < WIN; j++) begin
      rowok0[j] = (in_row_r >= ROW_W'(j)) && (in_row_r < (ROW_W'(h_use) + ROW_W'(j)));
    end
  end

  // The pixel released now sits RAD rows and RAD columns behind the input.
  assign has_out0 = (in_row_r > ROW_W'(RAD)) ||
                    ((in_row_r == ROW_W'(RAD)) && (in_col_r >= COL_W'(RAD)));
  assign ocol0    = (in_col_r >= COL_W'(RAD)) ? (in_col_r - COL_W'(RAD)) :
                    COL_W'(w_use - WU_W'(RAD) + WU_W'(in_col_r));
  assign last0    = (in_row_r == (ROW_W'(h_use) + ROW_W'(RAD))) &&
                    (in_col_r == COL_W'(RAD - 1));

  assign col_inc = WU_W'(in_col_r) + WU_W'(1);

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    wr_ptr_nxt = wr_ptr_r;
    if (size_write) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      wr_ptr_nxt = '0;
    end else if (accept) begin
      if (last0) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        wr_ptr_nxt = '0;
      end else begin
        wr_ptr_nxt = wr_ptr_r + ADDR_W'(1);
        if (col_inc >= w_use) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + ROW_W'(1);
        end else begin
          in_col_nxt = COL_W'(col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  // Column history: key bits of the six rows above, one word per column.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hist_r <= key_hist_mem[in_col_r];
    end
    if (s1_move) begin
      key_hist_mem[s1_col_r] <= hist_wr;
    end
  end

  // Pixel delay line, indexed by the raster position modulo its depth.
  always_ff @(posedge clk) begin
    if (accept && in_frame) begin
      pix_delay_mem[wr_ptr_r] <= {pr, pg, pb};
    end
    if (accept) begin
      s1_pix_r <= pix_delay_mem[wr_ptr_r - lag];
    end
  end

  // --------------------------------------------------------------- stage 1
  assign s2_adv   = !out_valid_r || out_ready;
  assign s1_adv   = !s2_valid_r || s2_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign s1_move  = s1_valid_r && s1_adv;
  assign s2_move  = s2_valid_r && s2_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key_r     <= key0;
      s1_rowok_r   <= rowok0;
      s1_col_r     <= in_col_r;
      s1_ocol_r    <= ocol0;
      s1_has_out_r <= has_out0;
      s1_last_r    <= last0;
    end
  end

  assign vcol    = {s1_hist_r, s1_key_r};
  assign vbit    = &(vcol | ~s1_rowok_r);
  assign hist_wr = {s1_hist_r[HIST_W-2:0], s1_key_r};

  // --------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_has_out_r <= s1_has_out_r;
      s2_last_r    <= s1_last_r;
      s2_ocol_r    <= s1_ocol_r;
      s2_pix_r     <= s1_pix_r;
    end
  end

  assign win_ctl.shift   = s1_move;
  assign win_ctl.vbit    = vbit;
  assign win_ctl.out_col = s2_ocol_r;
  assign win_ctl.width   = w_use;

  bske_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (win_ctl),
    .eroded (eroded)
  );

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= s2_valid_r && s2_has_out_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      out_pix_r  <= eroded ? s2_pix_r : '0;
      out_fg_r   <= eroded;
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_blue_out      = out_pix_r[PW-1:0];
  assign out_green_out     = out_pix_r[2*PW-1:PW];
  assign out_red_out       = out_pix_r[3*PW-1:2*PW];
  assign out_foreground    = out_fg_r;
  assign out_last_of_frame = out_last_r;

endmodule

// ----- dv/bske_erode_checker.sv -----
// Checker for blue_screen_key_erode_mask: it watches the request, result and register
// channels, predicts every result and compares it field by field. Depends on bske_pkg.
`timescale 1ns / 100ps

module bske_erode_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_mode,
  input  logic [bske_pkg::PIX_W-1:0]      in_blue_in,
  input  logic [bske_pkg::PIX_W-1:0]      in_green_in,
  input  logic [bske_pkg::PIX_W-1:0]      in_red_in,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [bske_pkg::PIX_W-1:0]      out_blue_out,
  input  logic [bske_pkg::PIX_W-1:0]      out_green_out,
  input  logic [bske_pkg::PIX_W-1:0]      out_red_out,
  input  logic                            out_foreground,
  input  logic                            out_last_of_frame,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bske_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bske_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              error_count,
  output int                              pending_count,
  output int                              results_checked,
  output int                              kept_count
);

  localparam int KEY_ROWS    = 8;
  localparam int PIX_W       = bske_pkg::PIX_W;
  localparam int FW_W        = bske_pkg::FW_W;
  localparam int FH_W        = bske_pkg::FH_W;
  localparam int MAX_WIDTH   = bske_pkg::MAX_WIDTH;
  localparam int DELAY_DEPTH = bske_pkg::DELAY_DEPTH;
  localparam int MIN_SIZE    = bske_pkg::MIN_SIZE;
  localparam int WIN_RAD     = bske_pkg::WIN_RAD;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             fg;
    logic             last;
  } masked_pixel_t;

  logic            key_mode_q;
  logic [FW_W-1:0] width_q;
  logic [FH_W-1:0] height_q;
  logic [7:0]      margin_q;

  bit              key_rows [KEY_ROWS][MAX_WIDTH];
  bit [23:0]       delay_line [DELAY_DEPTH];
  int unsigned     col_q;
  int unsigned     row_q;
  masked_pixel_t   masked_q[$];

  function automatic int unsigned used_width();
    if (width_q < MIN_SIZE) return MIN_SIZE;
    if (width_q > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_q);
  endfunction

  function automatic int unsigned used_height();
    if (height_q < MIN_SIZE) return MIN_SIZE;
    return int'(height_q);
  endfunction

  // The threshold is max(green, red) less the margin, floored at zero.
  function automatic bit keyed_foreground(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int lim;
    if (!key_mode_q) return 1'b1;
    lim = (g > r) ? int'(g) : int'(r);
    lim = (lim > int'(margin_q)) ? lim - int'(margin_q) : 0;
    return int'(b) < lim;
  endfunction

  // Any keyed-out bit inside the frame part of the 7x7 window clears the pixel.
  function automatic bit eroded(int orow, int ocol, int w, int h);
    int rr;
    int cc;
    for (int dy = -WIN_RAD; dy <= WIN_RAD; dy++) begin
      rr = orow + dy;
      if (rr < 0 || rr >= h) continue;
      for (int dx = -WIN_RAD; dx <= WIN_RAD; dx++) begin
        cc = ocol + dx;
        if (cc < 0 || cc >= w) continue;
        if (!key_rows[rr % KEY_ROWS][cc]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic predict_request(input logic pad, input logic [7:0] b_i, input logic [7:0] g_i,
                                 input logic [7:0] r_i);
    int unsigned   w;
    int unsigned   h;
    int unsigned   total;
    int unsigned   lag;
    int unsigned   n;
    int unsigned   p;
    logic [7:0]    b;
    logic [7:0]    g;
    logic [7:0]    r;
    bit            fg;
    bit [23:0]     pix;
    masked_pixel_t res;
    w     = used_width();
    h     = used_height();
    total = w * h;
    lag   = WIN_RAD * w + WIN_RAD;
    n     = row_q * w + col_q;
    b     = pad ? 8'd0 : b_i;
    g     = pad ? 8'd0 : g_i;
    r     = pad ? 8'd0 : r_i;
    // Past the end of the frame a request only pushes the flush along.
    if (n < total) begin
      key_rows[row_q % KEY_ROWS][col_q] = keyed_foreground(b, g, r);
      delay_line[n % DELAY_DEPTH] = {r, g, b};
    end
    col_q++;
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
    end
    if (n >= lag) begin
      p         = n - lag;
      fg        = eroded(p / w, p % w, w, h);
      pix       = fg ? delay_line[p % DELAY_DEPTH] : 24'd0;
      res.blue  = pix[7:0];
      res.green = pix[15:8];
      res.red   = pix[23:16];
      res.fg    = fg;
      res.last  = (p == total - 1);
      if (res.last) begin
        col_q = 0;
        row_q = 0;
      end
      masked_q.push_back(res);
    end
  endtask

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    masked_pixel_t want;
    if (!rst_n) begin
      key_mode_q = 1'b0;
      width_q    = FW_W'(640);
      height_q   = FH_W'(480);
      margin_q   = 8'd5;
      col_q      = 0;
      row_q      = 0;
      masked_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bske_pkg::CFG_KEY_MODE: key_mode_q = cfg_data[0];
          bske_pkg::CFG_FRAME_WIDTH: begin
            width_q = cfg_data[FW_W-1:0];
            col_q   = 0;
            row_q   = 0;
          end
          bske_pkg::CFG_FRAME_HEIGHT: begin
            height_q = cfg_data[FH_W-1:0];
            col_q    = 0;
            row_q    = 0;
          end
          bske_pkg::CFG_KEY_MARGIN: margin_q = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (masked_q.size() == 0) begin
          $error("result with no request waiting for it: blue %0d green %0d red %0d",
                 out_blue_out, out_green_out, out_red_out);
          error_count++;
        end else begin
          want = masked_q.pop_front();
          check_field("blue_out", want.blue, out_blue_out);
          check_field("green_out", want.green, out_green_out);
          check_field("red_out", want.red, out_red_out);
          check_field("foreground", want.fg, out_foreground);
          check_field("last_of_frame", want.last, out_last_of_frame);
          results_checked++;
          if (want.fg) kept_count++;
        end
      end
      if (in_valid && in_ready) predict_request(in_mode, in_blue_in, in_green_in, in_red_in);
    end
    pending_count = masked_q.size();
  end

endmodule

// ----- dv/tb_blue_screen_key_erode_mask.sv -----
// Testbench top for blue_screen_key_erode_mask: drives frames of keyed pixels, padding
// and register writes with random idling, and reports the verdict.
// Depends on bske_pkg, blue_screen_key_erode_mask and bske_erode_checker.
`timescale 1ns / 100ps

module tb_blue_screen_key_erode_mask;

  localparam int PIX_W      = bske_pkg::PIX_W;
  localparam int CFG_IDX_W  = bske_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = bske_pkg::CFG_DATA_W;
  localparam int MIN_SIZE   = bske_pkg::MIN_SIZE;
  localparam int MAX_WIDTH  = bske_pkg::MAX_WIDTH;
  localparam int WIN_RAD    = bske_pkg::WIN_RAD;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_mode;
  logic [PIX_W-1:0]      in_blue_in;
  logic [PIX_W-1:0]      in_green_in;
  logic [PIX_W-1:0]      in_red_in;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_blue_out;
  logic [PIX_W-1:0]      out_green_out;
  logic [PIX_W-1:0]      out_red_out;
  logic                  out_foreground;
  logic                  out_last_of_frame;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int error_count;
  int pending_count;
  int results_checked;
  int kept_count;

  int          ready_hold = 0;
  bit          stall_en = 1'b0;
  int          gap_odds = 0;
  int          items_sent = 0;
  int          settings_count = 0;
  int          widest = 0;
  int          tallest = 0;
  int          margin_now;
  int          w_use;
  int          h_use;
  logic [31:0] preset_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  blue_screen_key_erode_mask u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_blue_in        (in_blue_in),
    .in_green_in       (in_green_in),
    .in_red_in         (in_red_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_blue_out      (out_blue_out),
    .out_green_out     (out_green_out),
    .out_red_out       (out_red_out),
    .out_foreground    (out_foreground),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  bske_erode_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_blue_in        (in_blue_in),
    .in_green_in       (in_green_in),
    .in_red_in         (in_red_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_blue_out      (out_blue_out),
    .out_green_out     (out_green_out),
    .out_red_out       (out_red_out),
    .out_foreground    (out_foreground),
    .out_last_of_frame (out_last_of_frame),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .error_count       (error_count),
    .pending_count     (pending_count),
    .results_checked   (results_checked),
    .kept_count        (kept_count)
  );

  // Result backpressure: random stalls between ready stretches of varied length.
  always @(posedge clk) begin
    if (!stall_en) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 15);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 40);
    end
  end

  task automatic write_reg(input bske_pkg::cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper data bits are filled at random; the register keeps only its own width.
  task automatic apply_settings(input bit mode_v, input int mg, input int fw, input int fh,
                                input bit size_too);
    logic [CFG_DATA_W-1:0] data;
    data    = CFG_DATA_W'($urandom);
    data[0] = mode_v;
    write_reg(bske_pkg::CFG_KEY_MODE, data);
    data      = CFG_DATA_W'($urandom);
    data[7:0] = 8'(mg);
    write_reg(bske_pkg::CFG_KEY_MARGIN, data);
    margin_now = mg;
    if (size_too) begin
      data     = CFG_DATA_W'(fw);
      data[11] = 1'($urandom_range(0, 1));
      write_reg(bske_pkg::CFG_FRAME_WIDTH, data);
      write_reg(bske_pkg::CFG_FRAME_HEIGHT, CFG_DATA_W'(fh));
      w_use = (fw[10:0] < MIN_SIZE) ? MIN_SIZE : (fw[10:0] > MAX_WIDTH) ? MAX_WIDTH : fw[10:0];
      h_use = (fh < MIN_SIZE) ? MIN_SIZE : fh;
      if (w_use > widest) widest = w_use;
      if (h_use > tallest) tallest = h_use;
    end
    settings_count++;
  endtask

  // Builds a pixel on the chosen side of the key threshold, often right at its edge.
  task automatic make_pixel(input bit want_fg, output logic [7:0] b, output logic [7:0] g,
                            output logic [7:0] r);
    int m;
    int lim;
    int other;
    if (want_fg && margin_now < 255) begin
      m   = $urandom_range(margin_now + 1, 255);
      lim = m - margin_now;
      b   = ($urandom_range(0, 3) == 0) ? 8'(lim - 1) : 8'($urandom_range(0, lim - 1));
    end else begin
      m   = $urandom_range(0, 255);
      lim = (m > margin_now) ? m - margin_now : 0;
      b   = ($urandom_range(0, 3) == 0) ? 8'(lim) : 8'($urandom_range(lim, 255));
    end
    other = $urandom_range(0, m);
    if ($urandom_range(0, 1) == 1) begin
      g = 8'(m);
      r = 8'(other);
    end else begin
      r = 8'(m);
      g = 8'(other);
    end
  endtask

  task automatic send_item(input logic pad, input logic [7:0] b, input logic [7:0] g,
                           input logic [7:0] r);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= pad;
    in_blue_in  <= b;
    in_green_in <= g;
    in_red_in   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // One frame followed by its flush; abort_at cuts it short, bg_odds sets background density.
  task automatic run_frame(input int abort_at, input int bg_odds);
    int          span;
    logic        pad;
    logic [7:0]  b;
    logic [7:0]  g;
    logic [7:0]  r;
    logic [31:0] preset;
    span = w_use * h_use + WIN_RAD * w_use + WIN_RAD;
    for (int n = 0; n < span; n++) begin
      if (n == abort_at) break;
      if (preset_q.size() != 0) begin
        preset = preset_q.pop_front();
        pad    = preset[24];
        {b, g, r} = {preset[23:16], preset[15:8], preset[7:0]};
      end else if (n < w_use * h_use) begin
        pad = ($urandom_range(0, 39) == 0);
        make_pixel(bg_odds == 0 || $urandom_range(1, bg_odds) != 1, b, g, r);
      end else begin
        // Mostly padding during the flush; a real pixel here has its data dropped.
        pad = ($urandom_range(0, 5) != 0);
        {b, g, r} = 24'($urandom);
      end
      send_item(pad, b, g, r);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_count != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    // A request still in the warm-up stretch gives no result, so allow the pipeline depth.
    repeat (8) @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("tb_blue_screen_key_erode_mask: done, errors");
    $finish;
  end

  initial begin
    int  mg;
    int  fw;
    int  fh;
    int  frames;
    int  abort_at;
    int  bg_odds;
    int  span;
    bit  aborted;
    bit  mode_v;
    bit  size_too;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_mode     = 1'b0;
    in_blue_in  = '0;
    in_green_in = '0;
    in_red_in   = '0;
    cfg_valid   = 1'b0;
    cfg_index   = bske_pkg::CFG_KEY_MODE;
    cfg_data    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frame: threshold edges, saturated channels, padding inside the frame.
    stall_en = 1'b1;
    gap_odds = 6;
    apply_settings(1'b1, 5, 7, 7, 1'b1);
    preset_q = '{32'h0_000000, 32'h0_FFFFFF, 32'h0_00FF00, 32'h0_0000FF,
                 32'h0_F9FF00, 32'h0_FAFF00, 32'h0_000500, 32'h0_000006,
                 32'h0_FF0000, 32'h1_FFFFFF, 32'h0_64C896, 32'h0_6496C8};
    run_frame(-1, 0);
    drain();

    aborted = 1'b0;
    for (int k = 0; items_sent < 650; k++) begin
      mode_v = (k == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       mg = 0;
        1:       mg = 255;
        default: mg = $urandom_range(0, 60);
      endcase
      if (k == 0) mg = 0;
      if (k == 1) mg = 255;
      fw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 16);
      fh = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 10);
      size_too = aborted || k < 3 || $urandom_range(0, 2) != 0;
      aborted  = 1'b0;
      stall_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 4;
        default: gap_odds = 8;
      endcase
      apply_settings(mode_v, mg, fw, fh, size_too);
      frames = $urandom_range(1, 2);
      for (int f = 0; f < frames; f++) begin
        case ($urandom_range(0, 3))
          0:       bg_odds = 0;
          1:       bg_odds = 64;
          2:       bg_odds = 16;
          default: bg_odds = 2;
        endcase
        span     = w_use * h_use + WIN_RAD * w_use + WIN_RAD;
        abort_at = ($urandom_range(0, 4) == 0) ? $urandom_range(1, span - 1) : -1;
        run_frame(abort_at, bg_odds);
        if (abort_at >= 0) begin
          aborted = 1'b1;
          break;
        end
      end
      drain();
    end

    // Closing part without idling: the widest and tallest frame setting through part of
    // its warm-up, then a small frame run to completion after the size write restarts it.
    stall_en = 1'b0;
    gap_odds = 0;
    apply_settings(1'b1, $urandom_range(0, 40), 2047, 4095, 1'b1);
    run_frame(60, 256);
    drain();
    apply_settings(1'b1, $urandom_range(0, 40), $urandom_range(7, 16), 7, 1'b1);
    run_frame(-1, 16);
    drain();
    repeat (10) @(posedge clk);

    if (pending_count != 0) $error("%0d expected results never arrived", pending_count);
    $display("Covered %0d requests under %0d register settings, frame sizes up to %0d x %0d.",
             items_sent, settings_count, widest, tallest);
    $display("Checked %0d results, %0d of them kept as foreground.", results_checked,
             kept_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("tb_blue_screen_key_erode_mask: done, clean");
    end else begin
      $display("tb_blue_screen_key_erode_mask: done, errors");
    end
    $finish;
  end

endmodule
